### hw/rtl/gha_pkg.sv
// Shared widths, codes and types of the generational handle allocator.
package gha_pkg;

	localparam int unsigned SLOTS    = 1024;
	localparam int unsigned GEN_W    = 16;
	localparam int unsigned OWNER_W  = 16;
	localparam int unsigned IDX_W    = 11;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = $clog2(SLOTS);
	localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
	localparam int unsigned ENTRY_W  = 1 + GEN_W + OWNER_W;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic [IDX_W-1:0] EMPTY_INDEX = '1;
	localparam logic [GEN_W-1:0] GEN_SENTINEL = '1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
		logic [GEN_W-1:0]    gen;
		logic [OWNER_W-1:0]  owner;
	} res_t;

	// one slot table entry: alive flag, generation, owner
	typedef struct packed {
		logic               alive;
		logic [GEN_W-1:0]   gen;
		logic [OWNER_W-1:0] owner;
	} entry_t;

endpackage

### hw/rtl/gha_req_if.sv
// Request channel of the handle allocator: operation and handle.
interface gha_req_if import gha_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [IDX_W-1:0]    handle_index;
	logic [GEN_W-1:0]    handle_generation;
	logic [OWNER_W-1:0]  owner;

	modport source (output valid, opcode, handle_index, handle_generation, owner,
		input ready);
	modport sink (input valid, opcode, handle_index, handle_generation, owner,
		output ready);
endinterface

### hw/rtl/gha_rsp_if.sv
// Response channel of the handle allocator: status, handle, owner, pool length.
interface gha_rsp_if import gha_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot_index;
	logic [GEN_W-1:0]    slot_generation_out;
	logic [OWNER_W-1:0]  owner_out;
	logic [IDX_W-1:0]    slots_made;

	modport source (output valid, status, slot_index, slot_generation_out, owner_out,
		slots_made, input ready);
	modport sink (input valid, status, slot_index, slot_generation_out, owner_out,
		slots_made, output ready);
endinterface

### hw/rtl/generational_handle_allocator.sv
// Generational handle allocator: slot table and free stack in RAM, one op at a time.
// Steps, accept to response beat: allocate of a fresh slot, full, an out-of-range handle
// or an unused opcode go straight to the response step; lookup and release read the slot
// first; allocate from the free stack reads the stack, then the slot, both through a registered RAM read port.
// One request at a time; the next request is taken while the last
// response beat still waits. Reset clears the state and all registers of the block;
// table and stack contents stay undefined, no clearing pass.
module generational_handle_allocator import gha_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	gha_req_if.sink    req,
	gha_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STK,
		S_GEN,
		S_CHK,
		S_RESP
	} state_t;

	localparam res_t RES_STALE = '{status: ST_STALE, index: EMPTY_INDEX,
		gen: GEN_SENTINEL, owner: '0};
	localparam res_t RES_FULL  = '{status: ST_FULL, index: EMPTY_INDEX,
		gen: GEN_SENTINEL, owner: '0};

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [GEN_W-1:0]    hgen_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    free_top_q;
	logic [CNT_W-1:0]    used_count_q;
	res_t                res_q;
	logic                rsp_valid_q;
	res_t                rsp_res_q;
	logic [CNT_W-1:0]    rsp_made_q;

	// RAM ports
	logic                slot_we;
	logic [SLOT_W-1:0]   slot_waddr;
	entry_t              slot_wdata;
	logic [SLOT_W-1:0]   slot_raddr;
	entry_t              slot_rdata;
	logic                stk_we;
	logic [SLOT_W-1:0]   stk_waddr;
	logic [SLOT_W-1:0]   stk_wdata;
	logic [SLOT_W-1:0]   stk_raddr;
	logic [SLOT_W-1:0]   stk_rdata;

	logic                req_acc;
	logic                in_range;
	logic                have_free;
	logic                have_fresh;
	logic                stk_room;
	logic                chk_ok;
	logic [GEN_W-1:0]    gen_inc;
	logic [GEN_W-1:0]    gen_next;
	logic [CNT_W-1:0]    top_m1;

	gha_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Take a request only in idle; the response register drains on its own.
	assign req.ready  = (state_q == S_IDLE);
	assign req_acc    = req.valid && req.ready;

	// handle index and pool length share one width
	assign in_range   = (req.handle_index < used_count_q);
	assign have_free  = (free_top_q != '0);
	assign have_fresh = (used_count_q < CNT_W'(SLOTS));
	assign stk_room   = (free_top_q < CNT_W'(SLOTS));
	assign top_m1     = free_top_q - CNT_W'(1);

	// Handle check on the entry read back; the range test was done at accept.
	assign chk_ok     = slot_rdata.alive && (slot_rdata.gen == hgen_q);

	// Bump the generation, skip the invalid all-ones value.
	assign gen_inc    = slot_rdata.gen + GEN_W'(1);
	assign gen_next   = (gen_inc == GEN_SENTINEL) ? '0 : gen_inc;

	// Drive the RAM ports from the current step.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = '{alive: 1'b1, gen: gen_next, owner: owner_q};
		slot_raddr = req.handle_index[SLOT_W-1:0];
		stk_we     = 1'b0;
		stk_waddr  = free_top_q[SLOT_W-1:0];
		stk_wdata  = idx_q;
		stk_raddr  = top_m1[SLOT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				// fresh slot: write the new entry right at accept
				if (req_acc && (req.opcode == OP_ALLOC) && !have_free && have_fresh) begin
					slot_we    = 1'b1;
					slot_waddr = used_count_q[SLOT_W-1:0];
					slot_wdata = '{alive: 1'b1, gen: '0, owner: req.owner};
				end
			end
			S_STK: begin
				// popped index addresses the slot table
				slot_raddr = stk_rdata;
			end
			S_GEN: begin
				slot_we = 1'b1;
			end
			S_CHK: begin
				if (chk_ok && (op_q == OP_RELEASE)) begin
					slot_we    = 1'b1;
					slot_waddr = idx_q;
					slot_wdata = '{alive: 1'b0, gen: slot_rdata.gen, owner: slot_rdata.owner};
					stk_we     = stk_room;
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ALLOC;
			idx_q        <= '0;
			hgen_q       <= '0;
			owner_q      <= '0;
			slot_q       <= '0;
			free_top_q   <= '0;
			used_count_q <= '0;
			res_q        <= RES_STALE;
			rsp_valid_q  <= 1'b0;
			rsp_res_q    <= RES_STALE;
			rsp_made_q   <= '0;
		end else begin
			// drop the response beat once taken, unless a new one loads now
			if (rsp.valid && rsp.ready && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q    <= req.opcode;
						idx_q   <= req.handle_index[SLOT_W-1:0];
						hgen_q  <= req.handle_generation;
						owner_q <= req.owner;
						unique case (req.opcode)
							OP_ALLOC: begin
								if (have_free) begin
									state_q <= S_STK;
								end else if (have_fresh) begin
									used_count_q <= used_count_q + CNT_W'(1);
									res_q   <= '{status: ST_OK,
										index: IDX_W'(used_count_q[SLOT_W-1:0]),
										gen: '0, owner: '0};
									state_q <= S_RESP;
								end else begin
									res_q   <= RES_FULL;
									state_q <= S_RESP;
								end
							end
							OP_LOOKUP, OP_RELEASE: begin
								if (in_range) begin
									state_q <= S_CHK;
								end else begin
									res_q   <= RES_STALE;
									state_q <= S_RESP;
								end
							end
							default: begin
								res_q   <= RES_STALE;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_STK: begin
					// pop: hold the slot, wait for its generation
					slot_q     <= stk_rdata;
					free_top_q <= top_m1;
					state_q    <= S_GEN;
				end
				S_GEN: begin
					res_q   <= '{status: ST_OK, index: IDX_W'(slot_q), gen: gen_next,
						owner: '0};
					state_q <= S_RESP;
				end
				S_CHK: begin
					if (!chk_ok) begin
						res_q <= RES_STALE;
					end else if (op_q == OP_LOOKUP) begin
						res_q <= '{status: ST_OK, index: IDX_W'(idx_q), gen: hgen_q,
							owner: slot_rdata.owner};
					end else begin
						res_q <= '{status: ST_OK, index: IDX_W'(idx_q), gen: hgen_q,
							owner: '0};
						if (stk_room) begin
							free_top_q <= free_top_q + CNT_W'(1);
						end
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// load the response register when it is free or being drained
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_res_q   <= res_q;
						rsp_made_q  <= used_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.status              = rsp_res_q.status;
	assign rsp.slot_index          = rsp_res_q.index;
	assign rsp.slot_generation_out = rsp_res_q.gen;
	assign rsp.owner_out           = rsp_res_q.owner;
	assign rsp.slots_made          = IDX_W'(rsp_made_q);

	// Every stacked index is a slot already made.
	a_top_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_top_q <= used_count_q)
		else $error("free stack deeper than the pool");

	// A pop only follows a non-empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && req_acc && (req.opcode == OP_ALLOC) && have_free
		|=> (state_q == S_STK) && (free_top_q != '0))
		else $error("pop from an empty free stack");

	// A good response names a slot inside the pool.
	a_ok_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_OK)
		|-> (rsp.slot_index < rsp.slots_made))
		else $error("ok response outside the made slots");

endmodule

### hw/rtl/gha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the generational handle allocator, with its own slot-map predictor.

typedef struct {
	logic [gha_pkg::STATUS_W-1:0] status;
	logic [gha_pkg::IDX_W-1:0]    index;
	logic [gha_pkg::GEN_W-1:0]    gen;
	logic [gha_pkg::OWNER_W-1:0]  owner;
	logic [gha_pkg::IDX_W-1:0]    made;
} reply_t;

class handle_ledger;
	logic [gha_pkg::GEN_W-1:0]   gen_of [gha_pkg::SLOTS];
	bit                          alive_of [gha_pkg::SLOTS];
	logic [gha_pkg::OWNER_W-1:0] owner_of [gha_pkg::SLOTS];
	int unsigned                 free_list [$];
	int unsigned                 slots_used;
	reply_t                      awaited [$];
	int unsigned                 errors;

	function new();
		slots_used = 0;
		errors = 0;
		foreach (gen_of[i]) begin
			gen_of[i] = '0;
			alive_of[i] = 1'b0;
			owner_of[i] = '0;
		end
	endfunction

	function bit handle_live(int unsigned idx, logic [gha_pkg::GEN_W-1:0] g);
		if (idx >= slots_used)
			return 1'b0;
		return gen_of[idx] == g && alive_of[idx];
	endfunction

	// Advance the slot map by one accepted request and queue the reply it owes.
	function void note_request(logic [gha_pkg::OP_W-1:0] op, logic [gha_pkg::IDX_W-1:0] idx,
		logic [gha_pkg::GEN_W-1:0] hgen, logic [gha_pkg::OWNER_W-1:0] own);
		reply_t r;
		int unsigned slot;
		logic [gha_pkg::GEN_W-1:0] g;
		r.status = gha_pkg::ST_STALE;
		r.index = gha_pkg::EMPTY_INDEX;
		r.gen = gha_pkg::GEN_SENTINEL;
		r.owner = '0;
		case (op)
			gha_pkg::OP_ALLOC: begin
				if (free_list.size() > 0 || slots_used < gha_pkg::SLOTS) begin
					if (free_list.size() > 0) begin
						slot = free_list.pop_back();
						g = gen_of[slot] + 1'b1;
						if (g == gha_pkg::GEN_SENTINEL)
							g = '0;
					end else begin
						slot = slots_used;
						slots_used++;
						g = '0;
					end
					gen_of[slot] = g;
					alive_of[slot] = 1'b1;
					owner_of[slot] = own;
					r.status = gha_pkg::ST_OK;
					r.index = slot[gha_pkg::IDX_W-1:0];
					r.gen = g;
				end else begin
					r.status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::OP_LOOKUP: begin
				if (handle_live(idx, hgen)) begin
					r.status = gha_pkg::ST_OK;
					r.index = idx;
					r.gen = hgen;
					r.owner = owner_of[idx];
				end
			end
			gha_pkg::OP_RELEASE: begin
				if (handle_live(idx, hgen)) begin
					alive_of[idx] = 1'b0;
					if (free_list.size() < gha_pkg::SLOTS)
						free_list.push_back(idx);
					r.status = gha_pkg::ST_OK;
					r.index = idx;
					r.gen = hgen;
				end
			end
			default: begin
			end
		endcase
		r.made = slots_used[gha_pkg::IDX_W-1:0];
		awaited.push_back(r);
	endfunction

	function int unsigned field_diff(string name, logic [31:0] want, logic [31:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	function void check_response(reply_t got);
		reply_t want;
		if (awaited.size() == 0) begin
			$display("%0t: response beat with nothing outstanding: status %0d index %0d",
				$time, got.status, got.index);
			errors++;
			return;
		end
		want = awaited.pop_front();
		errors += field_diff("status", want.status, got.status);
		errors += field_diff("slot_index", want.index, got.index);
		errors += field_diff("slot_generation_out", want.gen, got.gen);
		errors += field_diff("owner_out", want.owner, got.owner);
		errors += field_diff("slots_made", want.made, got.made);
	endfunction
endclass

module testbench;
	import gha_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int unsigned     QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	gha_req_if req_ch ();
	gha_rsp_if rsp_ch ();

	generational_handle_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	handle_ledger ledger = new();

	// per side: 0 is the request sender, 1 the response receiver
	int unsigned calm_left [2] = '{0, 0};

	always #5 clk = ~clk;

	// Draw the wait before the next beat. Now and then open a calm stretch with no
	// gaps at all, so that back-to-back traffic is covered alongside idle phases.
	function automatic int unsigned draw_gap(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm_left[side] = $urandom_range(10, 60);
		return $urandom_range(0, 10);
	endfunction

	// Pick an index below the pool length, preferring a live slot.
	function automatic int unsigned pick_slot();
		int unsigned s;
		s = 0;
		repeat (4) begin
			s = $urandom_range(0, ledger.slots_used - 1);
			if (ledger.alive_of[s])
				break;
		end
		return s;
	endfunction

	// Present one request beat and hold it until the block takes it. Valid only
	// drops when a gap is drawn, so a back-to-back beat never toggles it.
	task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic [GEN_W-1:0] gen, input logic [OWNER_W-1:0] own);
		int unsigned gap;
		gap = draw_gap(0);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.handle_index <= idx;
		req_ch.handle_generation <= gen;
		req_ch.owner <= own;
		do @(posedge clk); while (!req_ch.ready);
		// the beat went in at this edge: advance the predictor before choosing the next
		ledger.note_request(op, idx, gen, own);
	endtask

	// Random traffic: mostly well-formed operations on handles the pool really
	// handed out, the rest stale, dead, out-of-range, empty or unused-opcode beats.
	task automatic mixed_traffic(input int unsigned beats);
		int unsigned roll;
		int unsigned s;
		logic [GEN_W-1:0] g;
		logic [OP_W-1:0] chk_op;
		repeat (beats) begin
			roll = $urandom_range(0, 99);
			chk_op = $urandom_range(0, 1) ? OP_LOOKUP : OP_RELEASE;
			if (roll < 35 || ledger.slots_used == 0) begin
				send_op(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom), OWNER_W'($urandom));
			end else if (roll < 85) begin
				s = pick_slot();
				send_op(roll < 60 ? OP_LOOKUP : OP_RELEASE, s[IDX_W-1:0], ledger.gen_of[s],
					OWNER_W'($urandom));
			end else begin
				case ($urandom_range(0, 5))
					0: begin
						// stale generation: flip one bit of the live one
						s = pick_slot();
						g = ledger.gen_of[s] ^ (16'd1 << $urandom_range(0, GEN_W - 1));
						send_op(chk_op, s[IDX_W-1:0], g, OWNER_W'($urandom));
					end
					1: send_op(chk_op, IDX_W'($urandom), GEN_W'($urandom),
						OWNER_W'($urandom));
					2: send_op(chk_op, EMPTY_INDEX, GEN_SENTINEL, OWNER_W'($urandom));
					3: send_op(OP_UNUSED, IDX_W'($urandom), GEN_W'($urandom),
						OWNER_W'($urandom));
					4: send_op(chk_op, ledger.slots_used[IDX_W-1:0], '0, OWNER_W'($urandom));
					default: begin
						s = pick_slot();
						send_op(chk_op, s[IDX_W-1:0], GEN_SENTINEL, OWNER_W'($urandom));
					end
				endcase
			end
		end
	endtask

	// Response side: draw a stall per beat, then take the beat and check it.
	initial begin
		reply_t got;
		int unsigned gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(1);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.status = rsp_ch.status;
			got.index = rsp_ch.slot_index;
			got.gen = rsp_ch.slot_generation_out;
			got.owner = rsp_ch.owner_out;
			got.made = rsp_ch.slots_made;
			ledger.check_response(got);
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_ALLOC;
		req_ch.handle_index <= '0;
		req_ch.handle_generation <= '0;
		req_ch.owner <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: handles against an empty pool, owner extremes, every opcode,
		// stale and dead handles, the empty handle, and LIFO reuse with a bumped
		// generation.
		send_op(OP_LOOKUP, '0, '0, '0);
		send_op(OP_RELEASE, EMPTY_INDEX, GEN_SENTINEL, '1);
		send_op(OP_UNUSED, '1, '1, '1);
		send_op(OP_ALLOC, '0, '0, '1);
		send_op(OP_ALLOC, '1, '1, '0);
		send_op(OP_ALLOC, '0, '0, 16'hA5A5);
		send_op(OP_LOOKUP, 11'd0, 16'd0, '0);
		send_op(OP_LOOKUP, 11'd1, 16'd0, '1);
		send_op(OP_LOOKUP, 11'd0, 16'd1, '0);
		send_op(OP_LOOKUP, 11'd3, 16'd0, '0);
		send_op(OP_LOOKUP, EMPTY_INDEX, GEN_SENTINEL, '0);
		send_op(OP_RELEASE, 11'd1, 16'd0, '0);
		send_op(OP_LOOKUP, 11'd1, 16'd0, '0);
		send_op(OP_RELEASE, 11'd1, 16'd0, '0);
		send_op(OP_RELEASE, 11'd0, 16'd0, '0);
		send_op(OP_ALLOC, '0, '0, 16'h1234);
		send_op(OP_ALLOC, '0, '0, 16'h8001);
		send_op(OP_ALLOC, '0, '0, 16'h5A5A);
		send_op(OP_LOOKUP, 11'd0, 16'd1, '0);
		send_op(OP_RELEASE, 11'd2, GEN_SENTINEL, '0);
		send_op(OP_UNUSED, '0, '0, '0);

		mixed_traffic(300);

		// Fill the pool: drain the free stack, take every fresh slot, then hit full.
		while (ledger.slots_used < SLOTS || ledger.free_list.size() > 0)
			send_op(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom), OWNER_W'($urandom));
		repeat (3) send_op(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom), OWNER_W'($urandom));

		mixed_traffic(450);

		// Drain: wait for every owed reply, then wait on for stray beats.
		req_ch.valid <= 1'b0;
		while (ledger.awaited.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (ledger.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
hw/rtl/gha_pkg.sv
hw/rtl/gha_req_if.sv
hw/rtl/gha_rsp_if.sv
hw/rtl/gha_ram.sv
hw/rtl/generational_handle_allocator.sv
bench/testbench.sv
